// ===== rtl/cpa_pkg.sv =====
package cpa_pkg;

	// datapath widths
	localparam int POS_W    = 32;
	localparam int SUM_W    = 33;                 // clamped + offset
	localparam int INV_W    = 32;
	localparam int HALF_W   = 16;                 // inverse distance split for the multiply
	localparam int PP_W     = SUM_W + HALF_W + 1; // one partial product
	localparam int PROD_W   = SUM_W + INV_W + 1;  // full signed product
	localparam int RATIO_W  = 33;                 // tangent, Q10
	localparam int FRAC_SH  = 32;                 // product >> 32
	localparam int CW       = 56;                 // CORDIC x/y width
	localparam int Y_SH     = 20;                 // y0 = ratio * 2^20
	localparam int X0_SH    = 30;                 // x0 = 2^30
	localparam int ZW       = 30;                 // angle accumulator
	localparam int CENTRE_W = 30;
	localparam int ANGLE_W  = 32;
	localparam int ORIENT_W = 62;

	// small queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = Q_AW + 1;

	// register map
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_X_MIN    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_X_MAX    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_Y_MIN    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_Y_MAX    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_X_OFF    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_Y_OFF    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_INV_DIST = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_ORIENT   = 3'd7;

	typedef struct packed {
		logic signed [POS_W-1:0] x_min;
		logic signed [POS_W-1:0] x_max;
		logic signed [POS_W-1:0] y_min;
		logic signed [POS_W-1:0] y_max;
		logic signed [POS_W-1:0] x_off;
		logic signed [POS_W-1:0] y_off;
		logic        [INV_W-1:0] inv_dist;
		logic     [ORIENT_W-1:0] orient;
	} cpa_cfg_t;

	typedef struct packed {
		logic signed [RATIO_W-1:0] ratio;
		logic                      axis;
		logic                      clamped;
	} cpa_item_t;

	typedef struct packed {
		logic v_s1;
		logic v_s2;
	} cpa_front_stat_t;

	// atan(2^-i) * 2^27, rounded
	function automatic logic signed [ZW-1:0] atan_entry(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 30'sd105414357;
			1: r = 30'sd62229729;
			2: r = 30'sd32880480;
			3: r = 30'sd16690645;
			4: r = 30'sd8377711;
			5: r = 30'sd4192939;
			6: r = 30'sd2096981;
			7: r = 30'sd1048555;
			8: r = 30'sd524285;
			9: r = 30'sd262144;
			default: r = (i < 28) ? (ZW'(1) << (27 - i)) : '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/clamped_position_to_pointing_angle.sv =====
// Channel   Handshake          Payload                         Notes
// item in   start / busy       axis_select, position           taken when start & !busy
// result    done (1 cycle)     angle, was_clamped              no back-pressure
// config    psel/penable/...   paddr[5:3] reg, pwdata 64 bit   8-byte stride, pready tied high
//
// One item per cycle sustained; the front pipeline, queue and unrolled CORDIC all advance
// every cycle. done rises after the accepting edge once the item has passed the multiply stage,
// one queue slot, CORDIC_STEPS iteration stages and the output register; taken at the next edge.
// The receiver cannot stall, so the queue drains every cycle and busy stays low in practice;
// it only guards the queue against overflow.
// arst_n clears control state and the configuration registers; datapath registers are not reset.
module clamped_position_to_pointing_angle #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	// item in
	input  logic               start,
	output logic               busy,
	input  logic               axis_select,
	input  logic signed [31:0] position,
	// result
	output logic               done,
	output logic signed [31:0] angle,
	output logic               was_clamped,
	// config
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);
	import cpa_pkg::*;

	cpa_cfg_t             cfg_q;
	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;

	logic                 accept;
	logic                 push, pop;
	cpa_item_t            push_item, pop_item;
	cpa_front_stat_t      front_stat;
	logic [Q_CW-1:0]      q_count;
	logic [Q_CW:0]        occupancy;
	logic                 pop_seen_q;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_X_MIN:    cfg_q.x_min    <= pwdata[31:0];
				REG_X_MAX:    cfg_q.x_max    <= pwdata[31:0];
				REG_Y_MIN:    cfg_q.y_min    <= pwdata[31:0];
				REG_Y_MAX:    cfg_q.y_max    <= pwdata[31:0];
				REG_X_OFF:    cfg_q.x_off    <= pwdata[31:0];
				REG_Y_OFF:    cfg_q.y_off    <= pwdata[31:0];
				REG_INV_DIST: cfg_q.inv_dist <= pwdata[31:0];
				REG_ORIENT:   cfg_q.orient   <= pwdata[ORIENT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_X_MIN:    prdata = 64'(unsigned'(cfg_q.x_min));
			REG_X_MAX:    prdata = 64'(unsigned'(cfg_q.x_max));
			REG_Y_MIN:    prdata = 64'(unsigned'(cfg_q.y_min));
			REG_Y_MAX:    prdata = 64'(unsigned'(cfg_q.y_max));
			REG_X_OFF:    prdata = 64'(unsigned'(cfg_q.x_off));
			REG_Y_OFF:    prdata = 64'(unsigned'(cfg_q.y_off));
			REG_INV_DIST: prdata = 64'(cfg_q.inv_dist);
			REG_ORIENT:   prdata = 64'(cfg_q.orient);
			default:      prdata = '0;
		endcase
	end

	// ---------------- item flow ----------------
	// busy once every queue slot is spoken for by queued or in-flight items
	assign occupancy = (Q_CW+1)'(q_count) + (Q_CW+1)'(front_stat.v_s1)
	                 + (Q_CW+1)'(front_stat.v_s2);
	assign busy      = (occupancy >= (Q_CW+1)'(Q_DEPTH));
	assign accept    = start & ~busy;

	// front: clamp, add offset, multiply by the inverse distance
	cpa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.axis_select (axis_select),
		.position    (position),
		.cfg         (cfg_q),
		.push        (push),
		.push_item   (push_item),
		.stat        (front_stat)
	);

	cpa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.count     (q_count)
	);

	// back: vectoring CORDIC and centre angle
	cpa_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (pop),
		.in_item     (pop_item),
		.orient      (cfg_q.orient),
		.done        (done),
		.angle       (angle),
		.was_clamped (was_clamped)
	);

	// registered copy of pop, for the drain check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_seen_q <= 1'b0;
		end else begin
			pop_seen_q <= pop;
		end
	end

	// ---------------- checks ----------------
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= Q_CW'(Q_DEPTH))
		else $error("item queue overflow");

	a_queue_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_count != Q_CW'(Q_DEPTH)) || pop)
		else $error("push into a full queue");

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(CORDIC_STEPS + 4) done)
		else $error("result did not appear at the expected latency");

	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count != '0) |=> pop_seen_q)
		else $error("queue held an item but the back end did not take it");

endmodule

// ===== rtl/cpa_front.sv =====
module cpa_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic                    axis_select,
	input  logic signed [31:0]      position,
	input  cpa_pkg::cpa_cfg_t       cfg,
	output logic                    push,
	output cpa_pkg::cpa_item_t      push_item,
	output cpa_pkg::cpa_front_stat_t stat
);
	import cpa_pkg::*;

	logic signed [POS_W-1:0]  lo, hi, off, lim;
	logic                     clamped;
	logic signed [SUM_W-1:0]  sum;

	logic                     v_s1, axis_s1, clamped_s1;
	logic signed [SUM_W-1:0]  sum_s1;

	logic                     v_s2, axis_s2, clamped_s2;
	logic signed [PP_W-1:0]   p_lo_s2, p_hi_s2;
	logic signed [PROD_W-1:0] prod;

	// clamp: min first, then max (inverted window keeps that order)
	always_comb begin
		lo  = axis_select ? cfg.y_min : cfg.x_min;
		hi  = axis_select ? cfg.y_max : cfg.x_max;
		off = axis_select ? cfg.y_off : cfg.x_off;
		if (position < lo) begin
			lim = lo;
		end else if (position > hi) begin
			lim = hi;
		end else begin
			lim = position;
		end
		clamped = (lim != position);
		sum     = SUM_W'(lim) + SUM_W'(off);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1     <= sum;
			axis_s1    <= axis_select;
			clamped_s1 <= clamped;
		end
		if (v_s1) begin
			p_lo_s2    <= PP_W'(sum_s1)
			            * PP_W'($signed({1'b0, cfg.inv_dist[HALF_W-1:0]}));
			p_hi_s2    <= PP_W'(sum_s1)
			            * PP_W'($signed({1'b0, cfg.inv_dist[INV_W-1:HALF_W]}));
			axis_s2    <= axis_s1;
			clamped_s2 <= clamped_s1;
		end
	end

	// recombine halves; arithmetic >> 32 floors
	assign prod = (PROD_W'(p_hi_s2) <<< HALF_W) + PROD_W'(p_lo_s2);

	assign push              = v_s2;
	assign push_item.ratio   = prod[RATIO_W+FRAC_SH-1:FRAC_SH];
	assign push_item.axis    = axis_s2;
	assign push_item.clamped = clamped_s2;

	assign stat.v_s1 = v_s1;
	assign stat.v_s2 = v_s2;

endmodule

// ===== rtl/cpa_queue.sv =====
module cpa_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  cpa_pkg::cpa_item_t         push_item,
	output logic                       pop,
	output cpa_pkg::cpa_item_t         pop_item,
	output logic [cpa_pkg::Q_CW-1:0]   count
);
	import cpa_pkg::*;

	cpa_item_t        mem_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [Q_CW-1:0]  count_q;

	// back end never stalls: drain whenever something is held
	assign pop      = (count_q != '0);
	assign pop_item = mem_q[rd_ptr_q];
	assign count    = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			count_q <= count_q + Q_CW'(push) - Q_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/cpa_cordic.sv =====
module cpa_cordic #(
	parameter int STEPS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  cpa_pkg::cpa_item_t                    in_item,
	input  logic [cpa_pkg::ORIENT_W-1:0]          orient,
	output logic                                  done,
	output logic signed [cpa_pkg::ANGLE_W-1:0]    angle,
	output logic                                  was_clamped
);
	import cpa_pkg::*;

	logic signed [CW-1:0] x_s [1:STEPS];
	logic signed [CW-1:0] y_s [1:STEPS];
	logic signed [ZW-1:0] z_s [1:STEPS];
	logic                 v_s [1:STEPS];
	logic                 axis_s [1:STEPS];
	logic                 clamped_s [1:STEPS];

	logic                       done_q, was_clamped_q;
	logic signed [ANGLE_W-1:0]  angle_q;
	logic signed [CENTRE_W-1:0] centre;
	logic                       neg;
	logic signed [ANGLE_W-1:0]  centre_w, z_w;

	for (genvar g = 0; g < STEPS; g++) begin : g_stage
		logic signed [CW-1:0] xc, yc, xsh, ysh;
		logic signed [ZW-1:0] zc, ang;
		logic                 vc, ac, cc;

		if (g == 0) begin : g_head
			assign xc = CW'(1) << X0_SH;
			assign yc = CW'(in_item.ratio) <<< Y_SH;
			assign zc = '0;
			assign vc = in_valid;
			assign ac = in_item.axis;
			assign cc = in_item.clamped;
		end else begin : g_body
			assign xc = x_s[g];
			assign yc = y_s[g];
			assign zc = z_s[g];
			assign vc = v_s[g];
			assign ac = axis_s[g];
			assign cc = clamped_s[g];
		end

		assign xsh = xc >>> g;
		assign ysh = yc >>> g;
		assign ang = atan_entry(g);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else begin
				v_s[g+1] <= vc;
			end
		end

		// y >= 0 rotates clockwise
		always_ff @(posedge clk) begin
			if (vc) begin
				if (!yc[CW-1]) begin
					x_s[g+1] <= xc + ysh;
					y_s[g+1] <= yc - xsh;
					z_s[g+1] <= zc + ang;
				end else begin
					x_s[g+1] <= xc - ysh;
					y_s[g+1] <= yc + xsh;
					z_s[g+1] <= zc - ang;
				end
				axis_s[g+1]    <= ac;
				clamped_s[g+1] <= cc;
			end
		end
	end

	always_comb begin
		centre   = axis_s[STEPS] ? orient[2*CENTRE_W-1:CENTRE_W] : orient[CENTRE_W-1:0];
		neg      = axis_s[STEPS] ? orient[2*CENTRE_W+1] : orient[2*CENTRE_W];
		centre_w = ANGLE_W'(centre);
		z_w      = ANGLE_W'(z_s[STEPS]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s[STEPS]) begin
			angle_q       <= neg ? (centre_w - z_w) : (centre_w + z_w);
			was_clamped_q <= clamped_s[STEPS];
		end
	end

	assign done        = done_q;
	assign angle       = angle_q;
	assign was_clamped = was_clamped_q;

endmodule

// ===== tb/pointing_checker.sv =====
module pointing_checker #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               axis_select,
	input  logic signed [31:0] position,
	input  logic               done,
	input  logic signed [31:0] angle,
	input  logic               was_clamped,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output int                 errors,
	output int                 pending,
	output int                 checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import cpa_pkg::*;

	typedef struct packed {
		logic signed [31:0] angle;
		logic               clamped;
	} pointing_t;

	// shadow of the block's registers
	logic signed [31:0] lim_x_lo = '0, lim_x_hi = '0, lim_y_lo = '0, lim_y_hi = '0;
	logic signed [31:0] ctr_x_off = '0, ctr_y_off = '0;
	logic [31:0]        inv_dist = '0;
	logic [61:0]        orient = '0;

	pointing_t angle_due[$];
	pointing_t head;

	// atan(2^-i) in 2^-27 rad
	function automatic longint arc_step(input int i);
		case (i)
			0: return 105414357;
			1: return 62229729;
			2: return 32880480;
			3: return 16690645;
			4: return 8377711;
			5: return 4192939;
			6: return 2096981;
			7: return 1048555;
			8: return 524285;
			9: return 262144;
			default: return (i < 28) ? (64'sd1 <<< (27 - i)) : 64'sd0;
		endcase
	endfunction

	function automatic pointing_t predict_pointing(input logic y_axis,
			input logic signed [31:0] pos);
		longint lo, hi, off, lim, s, ratio, cx, cy, cz, xs, ys, centre, ang;
		logic [63:0] mag, prod;
		logic neg;
		int i;
		pointing_t r;
		if (y_axis) begin
			lo = lim_y_lo;
			hi = lim_y_hi;
			off = ctr_y_off;
			centre = $signed(orient[59:30]);
			neg = orient[61];
		end else begin
			lo = lim_x_lo;
			hi = lim_x_hi;
			off = ctr_x_off;
			centre = $signed(orient[29:0]);
			neg = orient[60];
		end
		lim = pos;
		if (lim < lo)
			lim = lo;
		else if (lim > hi)
			lim = hi;
		s = lim + off;
		mag = (s < 0) ? -s : s;
		prod = mag * {32'd0, inv_dist};
		ratio = longint'(prod >> 32);
		// floor for negative sums: round the magnitude up
		if (s < 0) begin
			if (prod[31:0] != 32'd0)
				ratio = ratio + 1;
			ratio = -ratio;
		end
		cx = 64'sd1 <<< 30;
		cy = ratio * (64'sd1 <<< 20);
		cz = 0;
		for (i = 0; i < CORDIC_STEPS; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (cy >= 0) begin
				cx = cx + ys;
				cy = cy - xs;
				cz = cz + arc_step(i);
			end else begin
				cx = cx - ys;
				cy = cy + xs;
				cz = cz - arc_step(i);
			end
		end
		ang = neg ? centre - cz : centre + cz;
		r.angle = 32'(ang);
		r.clamped = (lim != pos);
		return r;
	endfunction

	task automatic report(input string msg);
		$display("tb: MISMATCH at %0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic report_leftover();
		while (angle_due.size() != 0) begin
			head = angle_due.pop_front();
			report($sformatf("no result for expected angle %0d", head.angle));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_x_lo <= '0;
			lim_x_hi <= '0;
			lim_y_lo <= '0;
			lim_y_hi <= '0;
			ctr_x_off <= '0;
			ctr_y_off <= '0;
			inv_dist <= '0;
			orient <= '0;
			angle_due.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (angle_due.size() == 0) begin
					report($sformatf("unexpected result angle %0d", angle));
				end else begin
					head = angle_due.pop_front();
					checked++;
					if (angle !== head.angle)
						report($sformatf("angle %0d, want %0d", angle, head.angle));
					if (was_clamped !== head.clamped)
						report($sformatf("was_clamped %b, want %b", was_clamped,
							head.clamped));
				end
			end
			// predict before any register write at the same edge takes effect
			if (start && !busy)
				angle_due.push_back(predict_pointing(axis_select, position));
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					REG_X_MIN:    lim_x_lo <= pwdata[31:0];
					REG_X_MAX:    lim_x_hi <= pwdata[31:0];
					REG_Y_MIN:    lim_y_lo <= pwdata[31:0];
					REG_Y_MAX:    lim_y_hi <= pwdata[31:0];
					REG_X_OFF:    ctr_x_off <= pwdata[31:0];
					REG_Y_OFF:    ctr_y_off <= pwdata[31:0];
					REG_INV_DIST: inv_dist <= pwdata[31:0];
					REG_ORIENT:   orient <= pwdata[61:0];
					default: ;
				endcase
			end
			pending <= angle_due.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cpa_pkg::*;

	localparam int STEPS = 24;
	// accept edge to done: front stages, queue slot, CORDIC stages, output register
	localparam int LATENCY = STEPS + 3;
	localparam int RAND_SETTINGS = 8;
	localparam int ITEMS_PER_SETTING = 240;

	localparam logic signed [31:0] P_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] P_MAX = 32'sh7fff_ffff;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               axis_select = 1'b0;
	logic signed [31:0] position = '0;
	logic               done;
	logic signed [31:0] angle;
	logic               was_clamped;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [5:0]         paddr = '0;
	logic [63:0]        pwdata = '0;
	logic [63:0]        prdata;
	logic               pready;

	int chk_errors, chk_pending, chk_checked;

	// stimulus bookkeeping: window per axis (0 = X, 1 = Y) to aim positions at
	longint win_lo[2], win_hi[2];
	int     n_items, n_settings;
	logic   bursting;

	clamped_position_to_pointing_angle #(.CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .axis_select(axis_select), .position(position),
		.done(done), .angle(angle), .was_clamped(was_clamped),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pointing_checker #(.CORDIC_STEPS(STEPS)) chk (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .axis_select(axis_select), .position(position),
		.done(done), .angle(angle), .was_clamped(was_clamped),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.errors(chk_errors), .pending(chk_pending), .checked(chk_checked)
	);

	always #10 clk = ~clk;

	// hard stop: well beyond the slowest legal run (~2000 items with long gaps)
	initial begin
		#20_000_000;
		$display("tb: done, errors");
		$finish;
	end

	// mostly back-to-back or short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 40);
	endfunction

	// APB write: setup, access, then an idle state so psel never toggles in one step
	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// one register setting; upper data bits of the 32-bit registers carry junk
	task automatic apply_setting(input logic signed [31:0] xl, xh, yl, yh, xo, yo,
			input logic [31:0] inv, input logic [63:0] ori);
		cfg_write(REG_X_MIN, {$urandom, xl});
		cfg_write(REG_X_MAX, {$urandom, xh});
		cfg_write(REG_Y_MIN, {$urandom, yl});
		cfg_write(REG_Y_MAX, {$urandom, yh});
		cfg_write(REG_X_OFF, {$urandom, xo});
		cfg_write(REG_Y_OFF, {$urandom, yo});
		cfg_write(REG_INV_DIST, {$urandom, inv});
		cfg_write(REG_ORIENT, ori);
		win_lo[0] = xl;
		win_hi[0] = xh;
		win_lo[1] = yl;
		win_hi[1] = yh;
		n_settings++;
	endtask

	// Holds start until the item is taken, then idles for a random gap.
	// With no gap start stays high: the caller sends the next item in the same step.
	task automatic send_item(input logic ax, input logic signed [31:0] pos);
		int gap;
		start <= 1'b1;
		axis_select <= ax;
		position <= pos;
		do @(posedge clk); while (busy);
		n_items++;
		gap = bursting ? 0 : pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			axis_select <= $urandom;
			position <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drain: start low, wait for every result, then the pipeline depth again
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// positions: inside the window, hugging its edges, near zero, or anything
	function automatic logic signed [31:0] gen_position(input logic ax);
		longint lo, hi, span, v;
		int r;
		lo = (win_lo[ax] < win_hi[ax]) ? win_lo[ax] : win_hi[ax];
		hi = (win_lo[ax] < win_hi[ax]) ? win_hi[ax] : win_lo[ax];
		span = hi - lo;
		r = $urandom_range(0, 99);
		if (r < 45)
			v = lo + longint'({$urandom, $urandom} % (span + 1));
		else if (r < 70)
			v = ($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 8) - 4;
		else if (r < 85)
			v = longint'($urandom_range(0, 4000)) - 2000;
		else
			v = $urandom;
		return 32'(v);
	endfunction

	// one random window: sensible mostly, sometimes full, inverted or wild
	task automatic random_window(output logic signed [31:0] lo, hi);
		int     style;
		longint c, half;
		style = $urandom_range(0, 9);
		if (style == 0) begin
			lo = P_MIN;
			hi = P_MAX;
		end else if (style == 1) begin
			lo = $urandom;
			hi = 32'(longint'(lo) - $urandom_range(1, 100000));
		end else if (style == 2) begin
			lo = $urandom;
			hi = $urandom;
		end else begin
			c = longint'($urandom_range(0, 400000)) - 200000;
			half = $urandom_range(0, 150000);
			lo = 32'(c - half);
			hi = 32'(c + half);
		end
	endtask

	task automatic random_setting();
		logic signed [31:0] xl, xh, yl, yh, xo, yo;
		logic [31:0]        inv;
		int                 r;
		random_window(xl, xh);
		random_window(yl, yh);
		xo = $urandom_range(0, 3) == 0 ? 32'($urandom) :
			32'(longint'($urandom_range(0, 200000)) - 100000);
		yo = $urandom_range(0, 3) == 0 ? 32'($urandom) :
			32'(longint'($urandom_range(0, 200000)) - 100000);
		// inverse distance: realistic throws mostly, with zero and raw values mixed in
		r = $urandom_range(0, 99);
		if (r < 5)
			inv = '0;
		else if (r < 15)
			inv = $urandom;
		else
			inv = 32'((64'd1 << 32) / $urandom_range(50, 20000));
		apply_setting(xl, xh, yl, yh, xo, yo, inv, {$urandom, $urandom});
	endtask

	initial begin
		logic signed [31:0] pt[8];
		int s, k;
		n_items = 0;
		n_settings = 0;
		bursting = 1'b1;
		win_lo = '{0, 0};
		win_hi = '{0, 0};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at their reset values: zero window, zero scale, zero centre
		send_item(1'b0, 32'sd0);
		send_item(1'b1, 32'sd1000);
		settle();

		// ordinary geometry; every field extreme and both window edges, both axes
		apply_setting(-32'sd100000, 32'sd100000, -32'sd50000, 32'sd80000,
			32'sd2500, -32'sd7000, 32'd4294967, {2'b10, 30'sd3000000, 30'sd1234567});
		for (k = 0; k < 2; k++) begin
			pt = '{32'sd0, -32'sd1, P_MIN, P_MAX, 32'(win_lo[k]), 32'(win_hi[k]),
				32'(win_lo[k] - 1), 32'(win_hi[k] + 1)};
			foreach (pt[j])
				if (k == 1 || j < 6)
					send_item(k[0], pt[j]);
		end
		settle();

		// extremes: full windows, largest offsets and scale, centre angles at the rails
		apply_setting(P_MIN, P_MAX, P_MIN, P_MAX, P_MAX, P_MIN, 32'hffff_ffff,
			{2'b10, 30'h2000_0000, 30'h1fff_ffff});
		send_item(1'b0, P_MAX);
		send_item(1'b0, P_MIN);
		send_item(1'b1, P_MAX);
		send_item(1'b1, P_MIN);
		settle();

		// inverted windows (min above max) with zero inverse distance, both signs set
		apply_setting(32'sd1000, -32'sd1000, 32'sd5, -32'sd5, 32'sd0, 32'sd0, 32'd0,
			{2'b11, -30'sd500000, 30'sd777777});
		send_item(1'b0, 32'sd0);
		send_item(1'b0, 32'sd2000);
		send_item(1'b1, -32'sd10);
		send_item(1'b1, 32'sd3);
		settle();

		// random settings; gaps switch on and off in stretches so some run back to back
		for (s = 0; s < RAND_SETTINGS; s++) begin
			random_setting();
			for (k = 0; k < ITEMS_PER_SETTING; k++) begin
				if (k % 40 == 0)
					bursting = ($urandom_range(0, 3) == 0);
				axis_select_pick: begin
					logic ax;
					ax = $urandom;
					send_item(ax, gen_position(ax));
				end
			end
			settle();
		end

		// final drain, bounded; anything still owed counts against the run
		start <= 1'b0;
		@(posedge clk);
		for (k = 0; k < 4 * LATENCY && chk_pending != 0; k++)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
		chk.report_leftover();

		$display("tb: %0d items over %0d register settings, %0d results compared",
			n_items, n_settings, chk_checked);
		$display("tb: windows normal/full/inverted, offsets and scale up to the rails");
		if (chk_errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
